// ----- sv/scancode_to_key_queue_assert.svh -----
// Assertion macros for the keyboard queue RTL.
`ifndef SCANCODE_TO_KEY_QUEUE_ASSERT_SVH
`define SCANCODE_TO_KEY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define SCKQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define SCKQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sckq_pkg.sv -----
package sckq_pkg;

    // Queue geometry; one slot always stays free
    localparam int QUEUE_DEPTH = 256;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Item operations
    typedef enum logic [1:0] {
        ACT_FEED  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_FLUSH = 2'd2
    } action_t;

    // Scancode constants
    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_CTRL   = 7'h1D;
    localparam logic [6:0] SC_ALT    = 7'h38;
    localparam logic [6:0] SC_CAPS   = 7'h3A;
    localparam logic [6:0] SC_F1     = 7'h3B;
    localparam logic [6:0] SC_F10    = 7'h44;
    localparam logic [6:0] SC_F11    = 7'h57;
    localparam logic [6:0] SC_F12    = 7'h58;

    // Special key codes
    localparam logic [7:0] KC_UP       = 8'h80;
    localparam logic [7:0] KC_DOWN     = 8'h81;
    localparam logic [7:0] KC_LEFT     = 8'h82;
    localparam logic [7:0] KC_RIGHT    = 8'h83;
    localparam logic [7:0] KC_HOME     = 8'h84;
    localparam logic [7:0] KC_END      = 8'h85;
    localparam logic [7:0] KC_PAGEUP   = 8'h86;
    localparam logic [7:0] KC_PAGEDOWN = 8'h87;
    localparam logic [7:0] KC_DELETE   = 8'h88;
    localparam logic [7:0] KC_F1       = 8'h89;
    localparam logic [7:0] KC_F11      = 8'h93;
    localparam logic [7:0] KC_F12      = 8'h94;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] scancode;
        logic       from_mouse;
    } in_item_t;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_code;
        logic       has_char;
        logic [7:0] peek_code;
        logic       overflow_dropped;
        logic       shift_held;
        logic       ctrl_held;
        logic       alt_held;
        logic       caps_lock_on;
    } out_item_t;

    // Decoder to queue: code request plus modifier state after the byte
    typedef struct packed {
        logic       push;
        logic [7:0] code;
        logic       shift_held;
        logic       ctrl_held;
        logic       alt_held;
        logic       caps_lock_on;
    } dec_t;

    // Ring index advance with wrap
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    // Extended cursor/edit keys, 0 when none
    function automatic logic [7:0] cursor_code(input logic [6:0] key);
        case (key)
            7'h48:   return KC_UP;
            7'h50:   return KC_DOWN;
            7'h4B:   return KC_LEFT;
            7'h4D:   return KC_RIGHT;
            7'h47:   return KC_HOME;
            7'h4F:   return KC_END;
            7'h49:   return KC_PAGEUP;
            7'h51:   return KC_PAGEDOWN;
            7'h53:   return KC_DELETE;
            default: return 8'h00;
        endcase
    endfunction

    // Unshifted ASCII table
    function automatic logic [7:0] plain_char(input logic [6:0] key);
        case (key)
            7'h01: return 8'h1B; 7'h02: return 8'h31; 7'h03: return 8'h32;
            7'h04: return 8'h33; 7'h05: return 8'h34; 7'h06: return 8'h35;
            7'h07: return 8'h36; 7'h08: return 8'h37; 7'h09: return 8'h38;
            7'h0A: return 8'h39; 7'h0B: return 8'h30; 7'h0C: return 8'h2D;
            7'h0D: return 8'h3D; 7'h0E: return 8'h08; 7'h0F: return 8'h09;
            7'h10: return 8'h71; 7'h11: return 8'h77; 7'h12: return 8'h65;
            7'h13: return 8'h72; 7'h14: return 8'h74; 7'h15: return 8'h79;
            7'h16: return 8'h75; 7'h17: return 8'h69; 7'h18: return 8'h6F;
            7'h19: return 8'h70; 7'h1A: return 8'h5B; 7'h1B: return 8'h5D;
            7'h1C: return 8'h0A; 7'h1E: return 8'h61; 7'h1F: return 8'h73;
            7'h20: return 8'h64; 7'h21: return 8'h66; 7'h22: return 8'h67;
            7'h23: return 8'h68; 7'h24: return 8'h6A; 7'h25: return 8'h6B;
            7'h26: return 8'h6C; 7'h27: return 8'h3B; 7'h28: return 8'h27;
            7'h29: return 8'h60; 7'h2B: return 8'h5C; 7'h2C: return 8'h7A;
            7'h2D: return 8'h78; 7'h2E: return 8'h63; 7'h2F: return 8'h76;
            7'h30: return 8'h62; 7'h31: return 8'h6E; 7'h32: return 8'h6D;
            7'h33: return 8'h2C; 7'h34: return 8'h2E; 7'h35: return 8'h2F;
            7'h37: return 8'h2A; 7'h39: return 8'h20;
            default: return 8'h00;
        endcase
    endfunction

    // Shifted ASCII table
    function automatic logic [7:0] shift_char(input logic [6:0] key);
        case (key)
            7'h01: return 8'h1B; 7'h02: return 8'h21; 7'h03: return 8'h40;
            7'h04: return 8'h23; 7'h05: return 8'h24; 7'h06: return 8'h25;
            7'h07: return 8'h5E; 7'h08: return 8'h26; 7'h09: return 8'h2A;
            7'h0A: return 8'h28; 7'h0B: return 8'h29; 7'h0C: return 8'h5F;
            7'h0D: return 8'h2B; 7'h0E: return 8'h08; 7'h0F: return 8'h09;
            7'h10: return 8'h51; 7'h11: return 8'h57; 7'h12: return 8'h45;
            7'h13: return 8'h52; 7'h14: return 8'h54; 7'h15: return 8'h59;
            7'h16: return 8'h55; 7'h17: return 8'h49; 7'h18: return 8'h4F;
            7'h19: return 8'h50; 7'h1A: return 8'h7B; 7'h1B: return 8'h7D;
            7'h1C: return 8'h0A; 7'h1E: return 8'h41; 7'h1F: return 8'h53;
            7'h20: return 8'h44; 7'h21: return 8'h46; 7'h22: return 8'h47;
            7'h23: return 8'h48; 7'h24: return 8'h4A; 7'h25: return 8'h4B;
            7'h26: return 8'h4C; 7'h27: return 8'h3A; 7'h28: return 8'h22;
            7'h29: return 8'h7E; 7'h2B: return 8'h7C; 7'h2C: return 8'h5A;
            7'h2D: return 8'h58; 7'h2E: return 8'h43; 7'h2F: return 8'h56;
            7'h30: return 8'h42; 7'h31: return 8'h4E; 7'h32: return 8'h4D;
            7'h33: return 8'h3C; 7'h34: return 8'h3E; 7'h35: return 8'h3F;
            7'h37: return 8'h2A; 7'h39: return 8'h20;
            default: return 8'h00;
        endcase
    endfunction

endpackage

// ----- sv/sckq_ram.sv -----
// Generic RAM: one write port, two registered read ports
module sckq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_a,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_b,
    output logic [WIDTH-1:0]                 rdata_a,
    output logic [WIDTH-1:0]                 rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- sv/sckq_decode.sv -----
// Set 1 scancode decoder: prefix and modifier tracking, key code lookup
module sckq_decode
    import sckq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       feed,       // keyboard byte accepted this cycle
    input  logic [7:0] scancode,
    output dec_t       dec
);

    logic lshift_reg, lshift_next;
    logic rshift_reg, rshift_next;
    logic lctrl_reg,  lctrl_next;
    logic rctrl_reg,  rctrl_next;
    logic lalt_reg,   lalt_next;
    logic ralt_reg,   ralt_next;
    logic caps_reg,   caps_next;
    logic prefix_reg, prefix_next;

    logic [6:0] key;
    logic [7:0] cur;
    logic [7:0] lower;
    logic [7:0] chr;
    logic       shifted;
    logic       push;
    logic [7:0] code;

    assign key   = scancode[6:0];
    assign cur   = cursor_code(key);
    assign lower = plain_char(key);

    // Caps lock flips shift for letters only
    always_comb begin
        shifted = lshift_reg | rshift_reg;
        if (caps_reg && lower >= 8'h61 && lower <= 8'h7A) begin
            shifted = ~shifted;
        end
        chr = shifted ? shift_char(key) : lower;
    end

    // Next modifier state and code request
    always_comb begin
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        lctrl_next  = lctrl_reg;
        rctrl_next  = rctrl_reg;
        lalt_next   = lalt_reg;
        ralt_next   = ralt_reg;
        caps_next   = caps_reg;
        prefix_next = prefix_reg;
        push        = 1'b0;
        code        = chr;
        if (feed) begin
            if (scancode == SC_PREFIX) begin
                prefix_next = 1'b1;
            end else begin
                prefix_next = 1'b0;
                if (scancode[7]) begin
                    // break: release modifiers only
                    if (key == SC_LSHIFT) begin
                        lshift_next = 1'b0;
                    end else if (key == SC_RSHIFT) begin
                        rshift_next = 1'b0;
                    end else if (key == SC_CTRL) begin
                        if (prefix_reg) rctrl_next = 1'b0;
                        else            lctrl_next = 1'b0;
                    end else if (key == SC_ALT) begin
                        if (prefix_reg) ralt_next = 1'b0;
                        else            lalt_next = 1'b0;
                    end
                end else if (key == SC_LSHIFT) begin
                    lshift_next = 1'b1;
                end else if (key == SC_RSHIFT) begin
                    rshift_next = 1'b1;
                end else if (key == SC_CTRL) begin
                    if (prefix_reg) rctrl_next = 1'b1;
                    else            lctrl_next = 1'b1;
                end else if (key == SC_ALT) begin
                    if (prefix_reg) ralt_next = 1'b1;
                    else            lalt_next = 1'b1;
                end else if (key == SC_CAPS) begin
                    caps_next = ~caps_reg;
                end else if (cur != 8'h00) begin
                    push = prefix_reg;
                    code = cur;
                end else if (key >= SC_F1 && key <= SC_F10) begin
                    push = 1'b1;
                    code = KC_F1 + 8'(key - SC_F1);
                end else if (key == SC_F11) begin
                    push = 1'b1;
                    code = KC_F11;
                end else if (key == SC_F12) begin
                    push = 1'b1;
                    code = KC_F12;
                end else begin
                    push = (chr != 8'h00);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lshift_reg <= 1'b0;
            rshift_reg <= 1'b0;
            lctrl_reg  <= 1'b0;
            rctrl_reg  <= 1'b0;
            lalt_reg   <= 1'b0;
            ralt_reg   <= 1'b0;
            caps_reg   <= 1'b0;
            prefix_reg <= 1'b0;
        end else begin
            lshift_reg <= lshift_next;
            rshift_reg <= rshift_next;
            lctrl_reg  <= lctrl_next;
            rctrl_reg  <= rctrl_next;
            lalt_reg   <= lalt_next;
            ralt_reg   <= ralt_next;
            caps_reg   <= caps_next;
            prefix_reg <= prefix_next;
        end
    end

    assign dec.push         = push;
    assign dec.code         = code;
    assign dec.shift_held   = lshift_next | rshift_next;
    assign dec.ctrl_held    = lctrl_next | rctrl_next;
    assign dec.alt_held     = lalt_next | ralt_next;
    assign dec.caps_lock_on = caps_next;

endmodule

// ----- sv/scancode_to_key_queue.sv -----
// PS/2 set 1 keyboard decoder with a key code ring queue.
// Input channel (s_valid/s_ready/s_item) carries one transaction per item:
// feed a scancode byte, pop one key code, or flush the queue. Aux-channel
// bytes (from_mouse) change nothing. Each input transaction yields exactly
// one result transaction on m_valid/m_ready/m_item: the popped code if any,
// queue status and front code after the item, an overflow flag and the
// modifier/caps-lock state.
// The result passes through the read stage and then the output register
// (the accepting edge does the queue RAM read; the output register loads when free).
// Throughput: one transaction per cycle while m_ready holds; the queue RAM
// has one write port and two registered read ports (front before and after
// the item), so an item never waits on the one before it.
// The queue holds QUEUE_DEPTH-1 codes; a code produced when it is full is
// dropped and flagged.
// Reset clears modifiers, caps lock, the prefix flag and both indices; the
// RAM contents are not cleared and no clearing pass is needed.
// When the receiver stalls, the result holds on m_item, one more item is
// taken into the read stage, and s_ready then drops until m_ready returns.
module scancode_to_key_queue
    import sckq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

`include "scancode_to_key_queue_assert.svh"

    dec_t dec;

    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_inc;

    logic       accept;
    logic       feed;
    logic       push_req;
    logic       full;
    logic       do_write;
    logic       drop;
    logic       pop_ok;

    // Read stage registers (RAM data registered inside the RAM)
    logic       rs_valid_reg;
    logic       rs_pop_reg;
    logic       rs_nonempty_reg;
    logic       rs_fwd_reg;
    logic [7:0] rs_fwd_code_reg;
    logic       rs_drop_reg;
    logic       rs_shift_reg;
    logic       rs_ctrl_reg;
    logic       rs_alt_reg;
    logic       rs_caps_reg;
    logic [7:0] rdata_a;
    logic [7:0] rdata_b;

    logic       out_load;
    logic       m_valid_reg;
    out_item_t  m_item_reg;
    out_item_t  res;

    // Handshake
    assign out_load = rs_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready  = ~rs_valid_reg | out_load;
    assign accept   = s_valid & s_ready;
    assign feed     = accept && (s_item.action == ACT_FEED) && !s_item.from_mouse;

    sckq_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .feed     (feed),
        .scancode (s_item.scancode),
        .dec      (dec)
    );

    // Queue index update
    assign wr_inc   = idx_inc(wr_idx_reg);
    assign full     = (wr_inc == rd_idx_reg);
    assign push_req = feed & dec.push;
    assign do_write = push_req & ~full;
    assign drop     = push_req & full;

    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        pop_ok      = 1'b0;
        if (accept) begin
            case (s_item.action)
                ACT_FEED: begin
                    if (do_write) wr_idx_next = wr_inc;
                end
                ACT_POP: begin
                    if (wr_idx_reg != rd_idx_reg) begin
                        pop_ok      = 1'b1;
                        rd_idx_next = idx_inc(rd_idx_reg);
                    end
                end
                ACT_FLUSH: begin
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // Port a reads the popped entry, port b the new front
    sckq_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .we      (do_write),
        .waddr   (wr_idx_reg),
        .wdata   (dec.code),
        .re      (accept),
        .raddr_a (rd_idx_reg),
        .raddr_b (rd_idx_next),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Read stage: side information; forward a code written into an empty queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_valid_reg <= 1'b0;
        end else if (accept) begin
            rs_valid_reg <= 1'b1;
        end else if (out_load) begin
            rs_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rs_pop_reg      <= pop_ok;
            rs_nonempty_reg <= (wr_idx_next != rd_idx_next);
            rs_fwd_reg      <= do_write && (wr_idx_reg == rd_idx_next);
            rs_fwd_code_reg <= dec.code;
            rs_drop_reg     <= drop;
            rs_shift_reg    <= dec.shift_held;
            rs_ctrl_reg     <= dec.ctrl_held;
            rs_alt_reg      <= dec.alt_held;
            rs_caps_reg     <= dec.caps_lock_on;
        end
    end

    // Result assembly
    always_comb begin
        res.read_valid       = rs_pop_reg;
        res.read_code        = rs_pop_reg ? rdata_a : 8'h00;
        res.has_char         = rs_nonempty_reg;
        res.peek_code        = !rs_nonempty_reg ? 8'h00 :
                               (rs_fwd_reg ? rs_fwd_code_reg : rdata_b);
        res.overflow_dropped = rs_drop_reg;
        res.shift_held       = rs_shift_reg;
        res.ctrl_held        = rs_ctrl_reg;
        res.alt_held         = rs_alt_reg;
        res.caps_lock_on     = rs_caps_reg;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Checks
    `SCKQ_ASSERT_NOW(a_empty_peek_zero, m_valid && !m_item.has_char,
        m_item.peek_code == 8'h00, "front code not zero on empty queue")
    `SCKQ_ASSERT_NEXT(a_pop_advances,
        accept && s_item.action == ACT_POP && wr_idx_reg != rd_idx_reg,
        rd_idx_reg != $past(rd_idx_reg), "pop on non-empty queue did not advance")
    `SCKQ_ASSERT_NOW(a_no_overrun, do_write, wr_inc != rd_idx_reg,
        "write index overran read index")
    `SCKQ_ASSERT_NOW(a_stall_blocks, rs_valid_reg && m_valid && !m_ready, !s_ready,
        "input taken while both stages are held")

endmodule

// ----- bench/tb_scancode_to_key_queue.sv -----
module tb_scancode_to_key_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import sckq_pkg::*;

    localparam logic [1:0]  ACT_UNUSED   = 2'd3;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          PRINT_CAP    = 40;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC,
        RDY_LONG_STALL
    } ready_mode_t;

    typedef enum int {
        MOD_LSHIFT,
        MOD_RSHIFT,
        MOD_LCTRL,
        MOD_RCTRL,
        MOD_LALT,
        MOD_RALT,
        MOD_NONE
    } modifier_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;

    // Scoreboard bookkeeping
    out_item_t   key_status_q [$];
    int          burst_left    = 0;
    int          items_sent    = 0;
    int          results_seen  = 0;
    int          codes_popped  = 0;
    int          drops_seen    = 0;
    int          errors        = 0;
    int unsigned quiet_cycles  = 0;

    // Model of the decoder and the key ring
    bit          lshift_dn, rshift_dn, lctrl_dn, rctrl_dn, lalt_dn, ralt_dn;
    bit          caps_on, ext_pending;
    bit [7:0]    code_ring [QUEUE_DEPTH];
    int          ring_wr, ring_rd;

    // Extended cursor/edit scancodes, in key code order from up arrow to delete
    bit [7:0] cursor_scans [9] = '{8'h48, 8'h50, 8'h4B, 8'h4D, 8'h47, 8'h4F,
                                   8'h49, 8'h51, 8'h53};

    // Set 1 make code to ASCII, without and with shift
    bit [7:0] lower_tab [58] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20};
    bit [7:0] upper_tab [58] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20};

    ready_mode_t ready_mode = RDY_ALWAYS;
    logic [6:0]  ready_tick = '0;

    scancode_to_key_queue DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Reference behavior
    // ---------------------------------------------------------------

    // Append to the ring; 1 when full and the code is lost
    function automatic bit push_code(bit [7:0] code);
        int nxt;
        nxt = (ring_wr + 1) % QUEUE_DEPTH;
        if (nxt == ring_rd) return 1'b1;
        code_ring[ring_wr] = code;
        ring_wr = nxt;
        return 1'b0;
    endfunction

    function automatic bit [7:0] cursor_key_code(bit [6:0] key);
        for (int i = 0; i < 9; i++) begin
            if (cursor_scans[i] == {1'b0, key}) return KC_UP + 8'(i);
        end
        return 8'h00;
    endfunction

    function automatic bit [7:0] ascii_for(bit [6:0] key, bit up);
        if (key >= 7'd58) return 8'h00;
        return up ? upper_tab[key[5:0]] : lower_tab[key[5:0]];
    endfunction

    // One keyboard byte; returns the overflow flag
    function automatic bit decode_byte(bit [7:0] sc);
        bit       ext;
        bit [6:0] key;
        bit [7:0] lower;
        bit [7:0] ch;
        bit       shifted;
        bit       lost;
        ext  = ext_pending;
        key  = sc[6:0];
        lost = 1'b0;
        if (sc == SC_PREFIX) begin
            ext_pending = 1'b1;
            return 1'b0;
        end
        ext_pending = 1'b0;

        // Break codes only release modifiers
        if (sc[7]) begin
            if (key == SC_LSHIFT) lshift_dn = 1'b0;
            else if (key == SC_RSHIFT) rshift_dn = 1'b0;
            else if (key == SC_CTRL) begin
                if (ext) rctrl_dn = 1'b0; else lctrl_dn = 1'b0;
            end else if (key == SC_ALT) begin
                if (ext) ralt_dn = 1'b0; else lalt_dn = 1'b0;
            end
            return 1'b0;
        end

        if (key == SC_LSHIFT) lshift_dn = 1'b1;
        else if (key == SC_RSHIFT) rshift_dn = 1'b1;
        else if (key == SC_CTRL) begin
            if (ext) rctrl_dn = 1'b1; else lctrl_dn = 1'b1;
        end else if (key == SC_ALT) begin
            if (ext) ralt_dn = 1'b1; else lalt_dn = 1'b1;
        end else if (key == SC_CAPS) caps_on = !caps_on;
        else if (cursor_key_code(key) != 8'h00) begin
            if (ext) lost = push_code(cursor_key_code(key));
        end else if (key >= SC_F1 && key <= SC_F10) begin
            lost = push_code(KC_F1 + 8'(key - SC_F1));
        end else if (key == SC_F11) begin
            lost = push_code(KC_F11);
        end else if (key == SC_F12) begin
            lost = push_code(KC_F12);
        end else begin
            // Caps lock flips shift for letters only
            shifted = lshift_dn || rshift_dn;
            lower   = ascii_for(key, 1'b0);
            if (caps_on && lower >= "a" && lower <= "z") shifted = !shifted;
            ch = ascii_for(key, shifted);
            if (ch != 8'h00) lost = push_code(ch);
        end
        return lost;
    endfunction

    // Expected result transaction for one accepted item
    function automatic out_item_t step_keyboard(in_item_t item);
        out_item_t r;
        r = '0;
        case (item.action)
            ACT_FEED: begin
                if (!item.from_mouse) r.overflow_dropped = decode_byte(item.scancode);
            end
            ACT_POP: begin
                if (ring_wr != ring_rd) begin
                    r.read_valid = 1'b1;
                    r.read_code  = code_ring[ring_rd];
                    ring_rd      = (ring_rd + 1) % QUEUE_DEPTH;
                end
            end
            ACT_FLUSH: begin
                ring_wr = 0;
                ring_rd = 0;
            end
            default: ;
        endcase
        r.has_char     = (ring_wr != ring_rd);
        r.peek_code    = r.has_char ? code_ring[ring_rd] : 8'h00;
        r.shift_held   = lshift_dn || rshift_dn;
        r.ctrl_held    = lctrl_dn || rctrl_dn;
        r.alt_held     = lalt_dn || ralt_dn;
        r.caps_lock_on = caps_on;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
    endtask

    // Receiver stall pattern, re-chosen whenever the 7-bit tick counter wraps
    always @(posedge aclk) begin
        if (ready_tick == '0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
        ready_tick <= ready_tick + 1'b1;
        case (ready_mode)
            RDY_ALWAYS:   m_ready <= 1'b1;
            RDY_RANDOM:   m_ready <= 1'($urandom_range(0, 1));
            RDY_PERIODIC: m_ready <= (ready_tick[2:0] >= 3'd3);
            default:      m_ready <= (ready_tick[4:0] >= 5'd20);
        endcase
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (key_status_q.size() == 0) begin
                report_mismatch("unexpected result", int'(m_item), 0);
            end else begin
                want = key_status_q.pop_front();
                if (m_item.read_valid !== want.read_valid)
                    report_mismatch("read_valid", int'(m_item.read_valid),
                                    int'(want.read_valid));
                if (m_item.read_code !== want.read_code)
                    report_mismatch("read_code", int'(m_item.read_code),
                                    int'(want.read_code));
                if (m_item.has_char !== want.has_char)
                    report_mismatch("has_char", int'(m_item.has_char),
                                    int'(want.has_char));
                if (m_item.peek_code !== want.peek_code)
                    report_mismatch("peek_code", int'(m_item.peek_code),
                                    int'(want.peek_code));
                if (m_item.overflow_dropped !== want.overflow_dropped)
                    report_mismatch("overflow_dropped", int'(m_item.overflow_dropped),
                                    int'(want.overflow_dropped));
                if (m_item.shift_held !== want.shift_held)
                    report_mismatch("shift_held", int'(m_item.shift_held),
                                    int'(want.shift_held));
                if (m_item.ctrl_held !== want.ctrl_held)
                    report_mismatch("ctrl_held", int'(m_item.ctrl_held),
                                    int'(want.ctrl_held));
                if (m_item.alt_held !== want.alt_held)
                    report_mismatch("alt_held", int'(m_item.alt_held),
                                    int'(want.alt_held));
                if (m_item.caps_lock_on !== want.caps_lock_on)
                    report_mismatch("caps_lock_on", int'(m_item.caps_lock_on),
                                    int'(want.caps_lock_on));
                if (want.read_valid) codes_popped++;
                if (want.overflow_dropped) drops_seen++;
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("tb_scancode_to_key_queue: FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Send one transaction; bursts of random length with random gaps between
    task automatic drive_item(in_item_t item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        s_valid <= 1'b1;
        s_item  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        items_sent++;
        key_status_q.push_back(step_keyboard(item));
    endtask

    task automatic feed_scancode(bit [7:0] sc, bit mouse);
        in_item_t item;
        item.action     = ACT_FEED;
        item.scancode   = sc;
        item.from_mouse = mouse;
        drive_item(item);
    endtask

    task automatic pop_key();
        in_item_t item;
        item.action     = ACT_POP;
        item.scancode   = 8'($urandom_range(0, 255));
        item.from_mouse = 1'($urandom_range(0, 1));
        drive_item(item);
    endtask

    task automatic flush_keys();
        in_item_t item;
        item.action     = ACT_FLUSH;
        item.scancode   = 8'($urandom_range(0, 255));
        item.from_mouse = 1'($urandom_range(0, 1));
        drive_item(item);
    endtask

    // Press or release one modifier; right ctrl and alt carry the prefix
    task automatic tap_modifier(modifier_t which, bit release_it);
        bit [6:0] base;
        case (which)
            MOD_LSHIFT:         base = SC_LSHIFT;
            MOD_RSHIFT:         base = SC_RSHIFT;
            MOD_LCTRL, MOD_RCTRL: base = SC_CTRL;
            default:            base = SC_ALT;
        endcase
        if (which == MOD_RCTRL || which == MOD_RALT) feed_scancode(SC_PREFIX, 1'b0);
        feed_scancode({release_it, base}, 1'b0);
    endtask

    // One key stroke: optional modifier, optional prefix, make, optional pop, break, optional release
    task automatic type_keystroke();
        modifier_t mod;
        bit        ext;
        bit [7:0]  key;
        int        kind;
        int        fkey;
        mod = $urandom_range(0, 1) ? MOD_NONE : modifier_t'($urandom_range(0, 5));
        if (mod != MOD_NONE) tap_modifier(mod, 1'b0);
        kind = $urandom_range(0, 9);
        ext  = 1'b0;
        if (kind < 6) begin
            key = 8'($urandom_range(1, 8'h39));
        end else if (kind < 8) begin
            key = cursor_scans[$urandom_range(0, 8)];
            ext = ($urandom_range(0, 3) != 0);
        end else if (kind == 8) begin
            fkey = $urandom_range(0, 11);
            if (fkey < 10) key = {1'b0, SC_F1} + 8'(fkey);
            else key = (fkey == 10) ? {1'b0, SC_F11} : {1'b0, SC_F12};
            ext = ($urandom_range(0, 5) == 0);
        end else begin
            key = 8'($urandom_range(0, 8'h7F));
        end
        if (ext) feed_scancode(SC_PREFIX, 1'b0);
        feed_scancode(key, 1'b0);
        if ($urandom_range(0, 3) == 0) pop_key();
        if (ext) feed_scancode(SC_PREFIX, 1'b0);
        feed_scancode(key | 8'h80, 1'b0);
        if (mod != MOD_NONE && $urandom_range(0, 4) != 0) tap_modifier(mod, 1'b1);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Field extremes, every action and each corner of the decoder
    task automatic test_directed_keys();
        in_item_t odd;
        pop_key();                              // pop on empty queue
        feed_scancode(8'h00, 1'b0);             // unmapped make
        feed_scancode(8'hFF, 1'b0);             // break of an unknown key
        feed_scancode({1'b0, SC_LSHIFT}, 1'b0);
        feed_scancode(8'h1E, 1'b0);             // shifted letter
        feed_scancode({1'b0, SC_CAPS}, 1'b0);
        feed_scancode(8'h1E, 1'b0);             // caps cancels shift on letters
        feed_scancode(8'h02, 1'b0);             // but not on digits
        feed_scancode({1'b1, SC_LSHIFT}, 1'b0);
        feed_scancode(cursor_scans[0], 1'b0);   // cursor key without prefix
        feed_scancode(SC_PREFIX, 1'b0);
        feed_scancode(8'h1E, 1'b1);             // mouse byte keeps the prefix
        feed_scancode(cursor_scans[0], 1'b0);   // extended up arrow
        feed_scancode(SC_PREFIX, 1'b0);
        feed_scancode({1'b0, SC_F12}, 1'b0);    // function key after prefix
        feed_scancode({1'b0, SC_F1}, 1'b0);
        feed_scancode({1'b0, SC_F11}, 1'b0);
        feed_scancode(SC_PREFIX, 1'b0);
        feed_scancode({1'b0, SC_ALT}, 1'b0);    // right alt
        feed_scancode({1'b0, SC_CTRL}, 1'b0);   // left ctrl
        feed_scancode(8'hE1, 1'b0);             // pause prefix, ignored
        odd.action     = ACT_UNUSED;
        odd.scancode   = 8'hFF;
        odd.from_mouse = 1'b1;
        drive_item(odd);
        pop_key();
        flush_keys();
        pop_key();
    endtask

    // Move the ring away from zero, fill it past full, then drain it
    task automatic test_queue_fill_and_wrap();
        bit [7:0] sc;
        int       n;
        n = $urandom_range(20, 60);
        for (int i = 0; i < n; i++) feed_scancode(8'h10 + 8'($urandom_range(0, 9)), 1'b0);
        repeat (n) pop_key();
        for (int i = 0; i < QUEUE_DEPTH + 3; i++) begin
            if ($urandom_range(0, 1)) sc = 8'h10 + 8'($urandom_range(0, 9));
            else sc = {1'b0, SC_F1} + 8'($urandom_range(0, 9));
            feed_scancode(sc, 1'b0);
        end
        repeat (QUEUE_DEPTH + 1) pop_key();
    endtask

    // Mostly well-formed typing, mixed with pops, flushes, mouse bytes and noise
    task automatic test_random_typing(int count);
        in_item_t junk;
        int       stop_at;
        int       pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                type_keystroke();
            end else if (pick < 65) begin
                repeat ($urandom_range(1, 4)) pop_key();
            end else if (pick < 68) begin
                flush_keys();
            end else if (pick < 73) begin
                feed_scancode({1'b0, SC_CAPS}, 1'b0);
            end else if (pick < 80) begin
                feed_scancode(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                junk.action     = 2'($urandom_range(0, 3));
                junk.scancode   = 8'($urandom_range(0, 255));
                junk.from_mouse = 1'($urandom_range(0, 1));
                drive_item(junk);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_keys();
        test_queue_fill_and_wrap();
        test_random_typing(650);

        // Let every outstanding result arrive, then watch for strays
        s_valid <= 1'b0;
        while (key_status_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items (feeds, pops, flushes, mouse bytes, unused action)",
                 items_sent);
        $display("checked %0d results: %0d codes popped, %0d overflow drops, %0d errors",
                 results_seen, codes_popped, drops_seen, errors);
        if (errors == 0) begin
            $display("tb_scancode_to_key_queue: PASS");
        end else begin
            $display("tb_scancode_to_key_queue: FAIL");
        end
        $finish;
    end

endmodule
